// ===== sv/dart_pkg.sv =====
// ----------------------------------------------------------------------------
// dart_pkg: shared types and constants for the divider and reload timer
// Field widths, register indexes, period lookup and the control and status
// structs between the sequencer and the tick unit.
// ----------------------------------------------------------------------------
package dart_pkg;

   localparam int CYCLES_W = 6;    // elapsed cycles per request
   localparam int COUNT_W  = 8;    // divider and counter width
   localparam int DIV_ACC_W = 8;   // divider accumulator, carry leaves at 256
   localparam int TICK_W   = 11;   // tick accumulator
   localparam int SEL_W    = 2;    // clock select
   localparam int CSR_IDX_W = 2;   // register index

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_SELECT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD_MODULO = 2'd2;

   // clock select codes
   localparam logic [SEL_W-1:0] SEL_1024 = 2'd0;
   localparam logic [SEL_W-1:0] SEL_16   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_64   = 2'd2;
   localparam logic [SEL_W-1:0] SEL_256  = 2'd3;

   typedef struct packed {
      logic start;     // new request: clear overflow flag
      logic add_en;    // add elapsed cycles to the tick accumulator
      logic iterate;   // take one period off and advance the counter
   } tick_ctrl_type;

   typedef struct packed {
      logic pending;   // enabled and accumulator at or above the period
      logic overflow;  // counter wrapped during the current request
   } tick_status_type;

   function automatic logic [TICK_W-1:0] period_of(input logic [SEL_W-1:0] sel);
      logic [TICK_W-1:0] period;
      unique case (sel)
         SEL_1024: period = 11'd1024;
         SEL_16:   period = 11'd16;
         SEL_64:   period = 11'd64;
         SEL_256:  period = 11'd256;
         default:  period = 11'd1024;
      endcase
      return period;
   endfunction

endpackage

// ===== sv/dart_tick_unit.sv =====
// ----------------------------------------------------------------------------
// dart_tick_unit: tick accumulator and programmable counter
// One shared adder either adds the elapsed cycles or removes one period per
// cycle; each removal advances the counter and reloads it on wrap.
// ----------------------------------------------------------------------------
module dart_tick_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  dart_pkg::tick_ctrl_type         tick_ctrl,
   input  logic [dart_pkg::CYCLES_W-1:0]   elapsed_cycles,
   input  logic                            timer_enable,
   input  logic [dart_pkg::SEL_W-1:0]      clock_select,
   input  logic [dart_pkg::COUNT_W-1:0]    reload_modulo,
   output dart_pkg::tick_status_type       tick_status,
   output logic [dart_pkg::COUNT_W-1:0]    counter_value
);
   import dart_pkg::*;

   logic [TICK_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;

   logic [TICK_W-1:0]  period;
   logic [TICK_W-1:0]  operand;
   logic [TICK_W-1:0]  acc_sum;
   logic [COUNT_W-1:0] count_inc;
   logic               wrap;

   assign period    = period_of(clock_select);
   // shared adder: add cycles, or subtract the period in two's complement
   assign operand   = tick_ctrl.add_en ? {{(TICK_W-CYCLES_W){1'b0}}, elapsed_cycles}
                                       : (~period + {{(TICK_W-1){1'b0}}, 1'b1});
   assign acc_sum   = acc_ff + operand;
   assign count_inc = count_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
   assign wrap      = (count_inc == '0);

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (tick_ctrl.add_en || tick_ctrl.iterate) begin
         acc_in = acc_sum;
      end
      if (tick_ctrl.start) begin
         ovf_in = 1'b0;
      end
      if (tick_ctrl.iterate) begin
         if (wrap) begin
            count_in = reload_modulo;
            ovf_in   = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign tick_status.pending  = timer_enable && (acc_ff >= period);
   assign tick_status.overflow = ovf_ff;
   assign counter_value        = count_ff;

`ifndef SYNTHESIS
   a_iterate_needs_pending: assert property (@(posedge clock) disable iff (reset)
      tick_ctrl.iterate |-> tick_status.pending)
      else $error("tick unit stepped with nothing pending");

   a_ovf_from_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(tick_ctrl.iterate))
      else $error("overflow flag set without a counter step");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      acc_ff < 11'd1087)
      else $error("tick accumulator beyond largest period plus one request");
`endif

endmodule

// ===== sv/divider_and_reload_timer.sv =====
// Sequencing: each request causes k counter increments (0 to 67); the single tick adder
//   removes one period per cycle, and the sequencer takes no request while it iterates
//   or while its response waits for the output register.
// Reset: synchronous, active high; clears all but the response payload registers.
// ----------------------------------------------------------------------------
// divider_and_reload_timer: free-running divider and reloadable timer
// Each request carries the cycle count of one emulated instruction. The
// divider advances at once; the timer counter is stepped by a shared
// subtract unit, one period per cycle, then the response is registered.
// ----------------------------------------------------------------------------
module divider_and_reload_timer (
   input  logic                             clock,
   input  logic                             reset,
   // configuration port
   input  logic                             csr_write_enable,
   input  logic [dart_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dart_pkg::COUNT_W-1:0]     csr_write_data,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dart_pkg::CYCLES_W-1:0]    req_elapsed_cycles,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dart_pkg::COUNT_W-1:0]     rsp_divider_value,
   output logic [dart_pkg::COUNT_W-1:0]     rsp_counter_value,
   output logic                             rsp_overflow_request
);
   import dart_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,   // wait for a request
      ST_RUN  = 2'b10    // step the counter, then hand off the response
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic               timer_enable_ff;
   logic [SEL_W-1:0]   clock_select_ff;
   logic [COUNT_W-1:0] reload_modulo_ff;

   // divider
   logic [DIV_ACC_W-1:0] div_acc_ff, div_acc_in;
   logic [COUNT_W-1:0]   div_count_ff, div_count_in;
   logic [DIV_ACC_W:0]   div_sum;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_divider_ff;
   logic [COUNT_W-1:0] rsp_counter_ff;
   logic               rsp_overflow_ff;

   logic               req_accept;
   logic               rsp_slot_free;
   logic               load_rsp;

   tick_ctrl_type      tick_ctrl;
   tick_status_type    tick_status;
   logic [COUNT_W-1:0] counter_value;

   // Take requests only in idle; a waiting response does not block intake.
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;
   // Hand off once no period is left to remove and the output register is free.
   assign load_rsp      = (state_ff == ST_RUN) && !tick_status.pending && rsp_slot_free;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_enable_ff  <= 1'b0;
         clock_select_ff  <= '0;
         reload_modulo_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TIMER_ENABLE:  timer_enable_ff  <= csr_write_data[0];
            CSR_CLOCK_SELECT:  clock_select_ff  <= csr_write_data[SEL_W-1:0];
            CSR_RELOAD_MODULO: reload_modulo_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Divider: add floor(cycles/4); carry out of bit 7 advances the count.
   assign div_sum = {1'b0, div_acc_ff}
                  + {{(DIV_ACC_W+1-(CYCLES_W-2)){1'b0}}, req_elapsed_cycles[CYCLES_W-1:2]};

   always_comb begin
      div_acc_in   = div_acc_ff;
      div_count_in = div_count_ff;
      if (req_accept) begin
         div_acc_in = div_sum[DIV_ACC_W-1:0];
         if (div_sum[DIV_ACC_W]) begin
            div_count_in = div_count_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // Sequencer: the accept cycle adds the cycles when the timer is enabled, then one period per cycle.
   always_comb begin
      state_in  = state_ff;
      tick_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            tick_ctrl.start  = req_accept;
            tick_ctrl.add_en = req_accept && timer_enable_ff;
            if (req_accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            tick_ctrl.iterate = tick_status.pending;
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_acc_ff   <= '0;
         div_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_acc_ff   <= div_acc_in;
         div_count_ff <= div_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload: load on hand-off, hold otherwise.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_divider_ff  <= div_count_ff;
         rsp_counter_ff  <= counter_value;
         rsp_overflow_ff <= tick_status.overflow;
      end
   end

   dart_tick_unit u_tick (
      .clock          (clock),
      .reset          (reset),
      .tick_ctrl      (tick_ctrl),
      .elapsed_cycles (req_elapsed_cycles),
      .timer_enable   (timer_enable_ff),
      .clock_select   (clock_select_ff),
      .reload_modulo  (reload_modulo_ff),
      .tick_status    (tick_status),
      .counter_value  (counter_value)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_divider_value    = rsp_divider_ff;
   assign rsp_counter_value    = rsp_counter_ff;
   assign rsp_overflow_request = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN))
      else $error("accepted request did not start the sequencer");

   a_load_when_settled: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !tick_status.pending)
      else $error("response loaded with counter steps outstanding");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("hand-off did not raise valid and return to idle");
`endif

endmodule
